// ===== hw/rtl/tpc_pkg.sv =====
`default_nettype none
package tpc_pkg;

   // configuration register indexes
   localparam logic [1:0] CSR_TEMP_COEFFS  = 2'd0;
   localparam logic [1:0] CSR_PRESS_LOW    = 2'd1;
   localparam logic [1:0] CSR_PRESS_HIGH   = 2'd2;
   localparam logic [1:0] CSR_PRESS_NINE   = 2'd3;

   // input commands
   localparam logic CMD_TEMPERATURE = 1'b0;
   localparam logic CMD_PRESSURE    = 1'b1;

   // calibration formula constants
   localparam logic [63:0] FINE_OFFSET = 64'd128000;
   localparam logic [63:0] PRESS_BASE  = 64'd1048576;
   localparam logic [63:0] PRESS_SCALE = 64'd3125;
   localparam logic [63:0] DEN_BIAS    = 64'd1 << 47;
   localparam int          DEN_SHIFT   = 33;
   localparam int          P4_SHIFT    = 35;

endpackage
`default_nettype wire

// ===== hw/rtl/temp_pressure_compensation.sv =====
`default_nettype none
// channel   dir  handshake                 payload
// req       in   req_tvalid/req_tready     tdata raw_reading, tuser command
// rsp       out  rsp_tvalid/rsp_tready     tdata compensated_value, tuser invalid
// csr       in   csr_valid/csr_ready       csr_index, csr_data
//
// one item at a time; each product of the shared shift-add multiplier passes a load
// state, a shift-add step per multiplier bit up to its top set bit and a done step;
// temperature takes 3 products; pressure takes 10 products plus a restoring divider
// of 64 quotient bits and a sign fix; a zero divisor ends after 6 products; the next
// transfer is accepted once the sequencer is back in idle
// reset clears state, coefficients, fine temperature and the result slot
// a waiting result does not block acceptance, but the next result holds its sequence
module temp_pressure_compensation
   import tpc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // [19:0] raw_reading, zero padded
   input  wire logic        req_tuser,   // [0] command
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [31:0] compensated_value
   output logic             rsp_tuser,   // [0] invalid
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [63:0] csr_data
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_LOAD = 3'd1;
   localparam logic [2:0] S_MUL  = 3'd2;
   localparam logic [2:0] S_DIV  = 3'd3;
   localparam logic [2:0] S_FIX  = 3'd4;
   localparam logic [2:0] S_FIN  = 3'd5;

   logic [2:0]  state_ff, state_in;
   logic [3:0]  step_ff, step_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        cmd_ff, cmd_in;
   logic [19:0] adc_ff, adc_in;
   logic        invalid_ff, invalid_in;
   logic        neg_ff, neg_in;
   logic [47:0] tco_ff, tco_in;
   logic [63:0] plo_ff, plo_in;
   logic [63:0] phi_ff, phi_in;
   logic [15:0] p9_ff, p9_in;
   logic [31:0] fine_ff, fine_in;
   logic [63:0] mand_ff, mand_in, mier_ff, mier_in, macc_ff, macc_in;
   logic [63:0] xx_ff, xx_in, quad_ff, quad_in, lin_ff, lin_in;
   logic [63:0] p_ff, p_in, h_ff, h_in, rem_ff, rem_in;
   logic        rsp_valid_ff, rsp_valid_in, rsp_user_ff, rsp_user_in;
   logic [31:0] rsp_data_ff, rsp_data_in;

   logic [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
   logic [63:0] x, hq, d1, d2, op_a, op_b, den, fine_sx, tsum, m;
   logic [64:0] rem_t;
   logic [65:0] diff;
   logic [31:0] res;

   // coefficient fields, sign extended except t1 and p1, which are zero extended
   assign t1 = {48'd0, tco_ff[15:0]};
   assign t2 = {{48{tco_ff[31]}}, tco_ff[31:16]};
   assign t3 = {{48{tco_ff[47]}}, tco_ff[47:32]};
   assign p1 = {48'd0, plo_ff[15:0]};
   assign p2 = {{48{plo_ff[31]}}, plo_ff[31:16]};
   assign p3 = {{48{plo_ff[47]}}, plo_ff[47:32]};
   assign p4 = {{48{plo_ff[63]}}, plo_ff[63:48]};
   assign p5 = {{48{phi_ff[15]}}, phi_ff[15:0]};
   assign p6 = {{48{phi_ff[31]}}, phi_ff[31:16]};
   assign p7 = {{48{phi_ff[47]}}, phi_ff[47:32]};
   assign p8 = {{48{phi_ff[63]}}, phi_ff[63:48]};
   assign p9 = {{48{p9_ff[15]}}, p9_ff};

   assign fine_sx = {{32{fine_ff[31]}}, fine_ff};
   assign x  = fine_sx - FINE_OFFSET;
   assign hq = $unsigned($signed(p_ff) >>> 13);
   assign d1 = {47'd0, adc_ff[19:3]} - {47'd0, t1[15:0], 1'b0};
   assign d2 = {48'd0, adc_ff[19:4]} - t1;
   assign m  = macc_ff;
   assign den = $unsigned($signed(m) >>> DEN_SHIFT);

   // divider step: shift in the next dividend bit and trial subtract
   assign rem_t = {rem_ff, p_ff[63]};
   assign diff  = {1'b0, rem_t} - {2'd0, h_ff};

   // product operands of each step
   always_comb begin
      op_a = x;
      op_b = x;
      if (cmd_ff == CMD_TEMPERATURE) begin
         case (step_ff)
            4'd0:    begin op_a = d1;      op_b = t2; end
            4'd1:    begin op_a = d2;      op_b = d2; end
            default: begin op_a = quad_ff; op_b = t3; end
         endcase
      end else begin
         case (step_ff)
            4'd0: begin op_a = x;  op_b = x;  end
            4'd1: begin op_a = xx_ff; op_b = p6; end
            4'd2: begin op_a = x;  op_b = p5; end
            4'd3: begin op_a = xx_ff; op_b = p3; end
            4'd4: begin op_a = x;  op_b = p2; end
            4'd5: begin op_a = DEN_BIAS + lin_ff; op_b = p1; end
            4'd6: begin
               op_a = ((PRESS_BASE - {44'd0, adc_ff}) << 31) - quad_ff;
               op_b = PRESS_SCALE;
            end
            4'd7: begin op_a = hq;    op_b = p9; end
            4'd8: begin op_a = xx_ff; op_b = hq; end
            default: begin op_a = p_ff; op_b = p8; end
         endcase
      end
   end

   // final result formatting
   always_comb begin
      tsum = (fine_sx << 2) + fine_sx + 64'd128;
      if (cmd_ff == CMD_TEMPERATURE) begin
         res = tsum[39:8];
      end else if (invalid_ff) begin
         res = 32'd0;
      end else begin
         res = lin_ff[39:8] + {p7[27:0], 4'd0};
      end
   end

   // sequencer and datapath next values
   always_comb begin
      state_in = state_ff;  step_in = step_ff;  cnt_in = cnt_ff;
      cmd_in = cmd_ff;  adc_in = adc_ff;  invalid_in = invalid_ff;  neg_in = neg_ff;
      tco_in = tco_ff;  plo_in = plo_ff;  phi_in = phi_ff;  p9_in = p9_ff;
      fine_in = fine_ff;
      mand_in = mand_ff;  mier_in = mier_ff;  macc_in = macc_ff;
      xx_in = xx_ff;  quad_in = quad_ff;  lin_in = lin_ff;
      p_in = p_ff;  h_in = h_ff;  rem_in = rem_ff;
      rsp_valid_in = rsp_valid_ff;  rsp_user_in = rsp_user_ff;  rsp_data_in = rsp_data_ff;

      // configuration writes
      if (csr_valid) begin
         case (csr_index)
            CSR_TEMP_COEFFS: tco_in = csr_data[47:0];
            CSR_PRESS_LOW:   plo_in = csr_data;
            CSR_PRESS_HIGH:  phi_in = csr_data;
            CSR_PRESS_NINE:  p9_in  = csr_data[15:0];
            default:         p9_in  = p9_ff;
         endcase
      end

      // result slot drains on transfer
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd_in     = req_tuser;
               adc_in     = req_tdata[19:0];
               step_in    = 4'd0;
               invalid_in = 1'b0;
               state_in   = S_LOAD;
            end
         end
         S_LOAD: begin
            mand_in  = op_a;
            mier_in  = op_b;
            macc_in  = 64'd0;
            state_in = S_MUL;
         end
         S_MUL: begin
            if (mier_ff != 64'd0) begin
               macc_in = macc_ff + (mier_ff[0] ? mand_ff : 64'd0);
               mand_in = mand_ff << 1;
               mier_in = mier_ff >> 1;
            end else begin
               step_in  = step_ff + 4'd1;
               state_in = S_LOAD;
               if (cmd_ff == CMD_TEMPERATURE) begin
                  case (step_ff)
                     4'd0: lin_in  = $unsigned($signed(m) >>> 11);
                     4'd1: quad_in = $unsigned($signed(m) >>> 12);
                     default: begin
                        fine_in  = lin_ff[31:0] + m[45:14];
                        state_in = S_FIN;
                     end
                  endcase
               end else begin
                  case (step_ff)
                     4'd0: xx_in   = m;
                     4'd1: quad_in = m;
                     4'd2: quad_in = quad_ff + (m << 17) + (p4 << P4_SHIFT);
                     4'd3: lin_in  = $unsigned($signed(m) >>> 8);
                     4'd4: lin_in  = lin_ff + (m << 12);
                     4'd5: begin
                        h_in = den;
                        if (den == 64'd0) begin
                           invalid_in = 1'b1;
                           state_in   = S_FIN;
                        end
                     end
                     4'd6: begin
                        neg_in   = m[63] ^ h_ff[63];
                        p_in     = m[63] ? (64'd0 - m) : m;
                        h_in     = h_ff[63] ? (64'd0 - h_ff) : h_ff;
                        rem_in   = 64'd0;
                        cnt_in   = 6'd0;
                        state_in = S_DIV;
                     end
                     4'd7: xx_in  = m;
                     4'd8: lin_in = $unsigned($signed(m) >>> 25);
                     default: begin
                        lin_in   = lin_ff + p_ff + $unsigned($signed(m) >>> 19);
                        state_in = S_FIN;
                     end
                  endcase
               end
            end
         end
         S_DIV: begin
            cnt_in = cnt_ff + 6'd1;
            if (!diff[65]) begin
               rem_in = diff[63:0];
               p_in   = {p_ff[62:0], 1'b1};
            end else begin
               rem_in = rem_t[63:0];
               p_in   = {p_ff[62:0], 1'b0};
            end
            if (cnt_ff == 6'd63) begin
               state_in = S_FIX;
            end
         end
         S_FIX: begin
            p_in     = neg_ff ? (64'd0 - p_ff) : p_ff;
            step_in  = 4'd7;
            state_in = S_LOAD;
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res;
               rsp_user_in  = invalid_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control, configuration and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         tco_ff       <= '0;
         plo_ff       <= '0;
         phi_ff       <= '0;
         p9_ff        <= '0;
         fine_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         tco_ff       <= tco_in;
         plo_ff       <= plo_in;
         phi_ff       <= phi_in;
         p9_ff        <= p9_in;
         fine_ff      <= fine_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      step_ff     <= step_in;
      cnt_ff      <= cnt_in;
      cmd_ff      <= cmd_in;
      adc_ff      <= adc_in;
      invalid_ff  <= invalid_in;
      neg_ff      <= neg_in;
      mand_ff     <= mand_in;
      mier_ff     <= mier_in;
      macc_ff     <= macc_in;
      xx_ff       <= xx_in;
      quad_ff     <= quad_in;
      lin_ff      <= lin_in;
      p_ff        <= p_in;
      h_ff        <= h_in;
      rem_ff      <= rem_in;
      rsp_user_ff <= rsp_user_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

`ifndef SYNTHESIS
   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == S_LOAD))
      else $error("accepted item did not start the sequencer");
   a_mul_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL && mier_ff == 64'd0) |=> (state_ff != S_MUL))
      else $error("multiplier did not release after its last bit");
   a_div_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV && cnt_ff == 6'd63) |=> (state_ff == S_FIX))
      else $error("divider ran past 64 quotient bits");
   a_temp_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN && (!rsp_valid_ff || rsp_tready)
       && cmd_ff == CMD_TEMPERATURE) |=> (rsp_tvalid && !rsp_tuser))
      else $error("temperature result flagged invalid");
`endif

endmodule
`default_nettype wire

// ===== tb/temp_pressure_compensation_test.sv =====
`default_nettype none
module temp_pressure_compensation_test;
   import tpc_pkg::*;

   localparam int CYCLE_LIMIT = 4000000;

   typedef struct {
      logic [31:0] value;
      logic        invalid;
   } reading_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [63:0] csr_data = '0;

   // predictor copy of the calibration registers and fine temperature
   logic [47:0]        temp_coeffs;
   logic [63:0]        press_low;
   logic [63:0]        press_high;
   logic [15:0]        press_nine;
   logic signed [31:0] fine_temp;

   reading_type pending_readings[$];
   int errors;
   int cycles;
   int temps_sent;
   int pressures_sent;
   int invalids_seen;
   int checked;
   bit req_gaps;
   bit rsp_stalls;
   int long_hold;
   int stall_left;

   temp_pressure_compensation dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #2 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // signed division truncated toward zero, most negative / -1 wraps
   function automatic longint div_trunc(input longint a, input longint b);
      bit [63:0] ua;
      bit [63:0] ub;
      bit [63:0] q;
      ua = a[63] ? -a : a;
      ub = b[63] ? -b : b;
      q  = ua / ub;
      return (a[63] != b[63]) ? longint'(-q) : longint'(q);
   endfunction

   function automatic reading_type compensate(input logic cmd, input logic [19:0] raw);
      reading_type r;
      longint adc, t1, t2, t3, d1, d2, ta, tb, fine;
      longint p1, p2, p3, p4, p5, p6, p7, p8, p9;
      longint x, lin, quad, den, p, h;
      adc = longint'({44'd0, raw});
      r.invalid = 1'b0;
      if (cmd == CMD_TEMPERATURE) begin
         t1 = longint'({48'd0, temp_coeffs[15:0]});
         t2 = longint'($signed(temp_coeffs[31:16]));
         t3 = longint'($signed(temp_coeffs[47:32]));
         d1 = (adc >> 3) - (t1 << 1);
         ta = (d1 * t2) >>> 11;
         d2 = (adc >> 4) - t1;
         tb = (((d2 * d2) >>> 12) * t3) >>> 14;
         fine_temp = ta[31:0] + tb[31:0];
         fine = longint'(fine_temp);
         p = (fine * 5 + 128) >>> 8;
         r.value = p[31:0];
      end else begin
         p1 = longint'({48'd0, press_low[15:0]});
         p2 = longint'($signed(press_low[31:16]));
         p3 = longint'($signed(press_low[47:32]));
         p4 = longint'($signed(press_low[63:48]));
         p5 = longint'($signed(press_high[15:0]));
         p6 = longint'($signed(press_high[31:16]));
         p7 = longint'($signed(press_high[47:32]));
         p8 = longint'($signed(press_high[63:48]));
         p9 = longint'($signed(press_nine));
         x = longint'(fine_temp) - 128000;
         quad = x * x * p6;
         quad = quad + ((x * p5) << 17);
         quad = quad + (p4 << 35);
         lin = ((x * x * p3) >>> 8) + ((x * p2) << 12);
         den = (((longint'(1) << 47) + lin) * p1) >>> 33;
         if (den == 0) begin
            r.value = '0;
            r.invalid = 1'b1;
         end else begin
            p = 1048576 - adc;
            p = div_trunc(((p << 31) - quad) * 3125, den);
            h = p >>> 13;
            lin = (p9 * h * h) >>> 25;
            quad = (p8 * p) >>> 19;
            p = ((p + lin + quad) >>> 8) + (p7 << 4);
            r.value = p[31:0];
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s at cycle %0d: got %h expected %h", what, cycles, got, want);
      errors++;
   endtask

   // result receiver: random and long stalls, field checks
   always @(posedge clock) begin
      reading_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_readings.size() == 0) begin
               report_mismatch("unexpected result", rsp_tdata, '0);
            end else begin
               want = pending_readings.pop_front();
               checked++;
               if (rsp_tuser) invalids_seen++;
               if (rsp_tdata !== want.value)
                  report_mismatch("compensated_value", rsp_tdata, want.value);
               if (rsp_tuser !== want.invalid)
                  report_mismatch("invalid", {31'd0, rsp_tuser}, {31'd0, want.invalid});
            end
         end
         if (long_hold > 0) begin
            long_hold = long_hold - 1;
            rsp_tready <= 1'b0;
         end else if (rsp_stalls && stall_left > 0) begin
            stall_left = stall_left - 1;
            rsp_tready <= 1'b0;
         end else if (rsp_stalls && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 8);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic write_csr(input logic [1:0] idx, input logic [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_TEMP_COEFFS: temp_coeffs = value[47:0];
         CSR_PRESS_LOW:   press_low   = value;
         CSR_PRESS_HIGH:  press_high  = value;
         CSR_PRESS_NINE:  press_nine  = value[15:0];
         default:         ;
      endcase
   endtask

   task automatic load_coeffs(input logic [47:0] tc, input logic [63:0] pl,
                              input logic [63:0] ph, input logic [15:0] p9);
      write_csr(CSR_TEMP_COEFFS, {16'd0, tc});
      write_csr(CSR_PRESS_LOW, pl);
      write_csr(CSR_PRESS_HIGH, ph);
      write_csr(CSR_PRESS_NINE, {48'd0, p9});
   endtask

   // one transfer on the request channel, prediction at acceptance
   task automatic send_reading(input logic cmd, input logic [19:0] raw);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= {4'd0, raw};
      req_tuser  <= cmd;
      do @(posedge clock); while (!req_tready);
      pending_readings.push_back(compensate(cmd, raw));
      if (cmd == CMD_TEMPERATURE) temps_sent++;
      else pressures_sent++;
      if (req_gaps && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 9);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
   endtask

   function automatic logic [19:0] random_raw();
      case ($urandom_range(0, 5))
         0: return 20'h00000;
         1: return 20'hFFFFF;
         2: return 20'(380000 + $urandom_range(0, 250000));
         default: return 20'($urandom_range(0, 20'hFFFFF));
      endcase
   endfunction

   // datasheet-like calibration nudged at random, or fully random, extreme or zero P1 sets
   task automatic load_random_coeffs;
      logic [47:0] tc;
      logic [63:0] pl, ph;
      logic [15:0] p9;
      case ($urandom_range(0, 4))
         0: begin
            tc = 48'({$urandom, $urandom});
            pl = {$urandom, $urandom};
            ph = {$urandom, $urandom};
            p9 = 16'($urandom);
         end
         1: begin
            tc = {16'hFFFF, 16'hFFFF, 16'hFFFF};
            pl = $urandom_range(0, 1) ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h7FFF_7FFF_7FFF_FFFF;
            ph = $urandom_range(0, 1) ? 64'h8000_8000_8000_8000 : 64'h7FFF_7FFF_7FFF_7FFF;
            p9 = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
         end
         2: begin
            // zero P1 forces the zero divisor
            tc = {16'(-1000 + $urandom_range(0, 200)), 16'(26000 + $urandom_range(0, 900)),
                  16'(27000 + $urandom_range(0, 900))};
            pl = {16'(2855), 16'(3024), 16'(-10685), 16'd0};
            ph = {16'(-14600), 16'(15500), 16'(-7), 16'(140)};
            p9 = 16'(6000);
         end
         default: begin
            tc = {16'(-1000 + $urandom_range(0, 200)), 16'(26000 + $urandom_range(0, 900)),
                  16'(27000 + $urandom_range(0, 900))};
            pl = {16'(2855 + $urandom_range(0, 99)), 16'(3024 + $urandom_range(0, 99)),
                  16'(-10685 + $urandom_range(0, 99)), 16'(36000 + $urandom_range(0, 999))};
            ph = {16'(-14600 + $urandom_range(0, 99)), 16'(15500 + $urandom_range(0, 99)),
                  16'(-7 + $urandom_range(0, 3)), 16'(140 + $urandom_range(0, 20))};
            p9 = 16'(6000 + $urandom_range(0, 99));
         end
      endcase
      load_coeffs(tc, pl, ph, p9);
   endtask

   // reset coefficients: pressure before any temperature, zero divisor
   task automatic test_reset_state;
      send_reading(CMD_PRESSURE, 20'd415148);
      send_reading(CMD_TEMPERATURE, 20'd519888);
      send_reading(CMD_PRESSURE, 20'hFFFFF);
      drain();
   endtask

   // typical calibration and field extremes
   task automatic test_directed;
      load_coeffs({16'(-1000), 16'(26435), 16'(27504)},
                  {16'(2855), 16'(3024), 16'(-10685), 16'(36477)},
                  {16'(-14600), 16'(15500), 16'(-7), 16'(140)}, 16'(6000));
      send_reading(CMD_PRESSURE, 20'd415148);
      send_reading(CMD_TEMPERATURE, 20'd519888);
      send_reading(CMD_PRESSURE, 20'd415148);
      send_reading(CMD_PRESSURE, 20'd0);
      send_reading(CMD_PRESSURE, 20'hFFFFF);
      send_reading(CMD_TEMPERATURE, 20'd0);
      send_reading(CMD_PRESSURE, 20'hAAAAA);
      send_reading(CMD_TEMPERATURE, 20'hFFFFF);
      send_reading(CMD_PRESSURE, 20'h55555);
      drain();
      // near-largest coefficients (T3 is -1): pressure intermediates wrap
      load_coeffs(48'hFFFF_7FFF_FFFF, 64'h7FFF_7FFF_7FFF_FFFF,
                  64'h7FFF_7FFF_7FFF_7FFF, 16'h7FFF);
      send_reading(CMD_TEMPERATURE, 20'd0);
      send_reading(CMD_PRESSURE, 20'd0);
      send_reading(CMD_TEMPERATURE, 20'hFFFFF);
      send_reading(CMD_PRESSURE, 20'hFFFFF);
      drain();
      load_coeffs(48'h8000_8000_0000, 64'h8000_8000_8000_0001,
                  64'h8000_8000_8000_8000, 16'h8000);
      send_reading(CMD_TEMPERATURE, 20'hFFFFF);
      send_reading(CMD_PRESSURE, 20'd0);
      send_reading(CMD_TEMPERATURE, 20'd0);
      send_reading(CMD_PRESSURE, 20'hFFFFF);
      drain();
   endtask

   // phases of random calibration, a random mix of mostly pressure readings
   task automatic test_random_phases(input int phases, input int per_phase);
      for (int ph = 0; ph < phases; ph++) begin
         load_random_coeffs();
         for (int i = 0; i < per_phase; i++) begin
            if ($urandom_range(0, 3) == 0) send_reading(CMD_TEMPERATURE, random_raw());
            else send_reading(CMD_PRESSURE, random_raw());
         end
         drain();
      end
   endtask

   // receiver holds off while the sender keeps offering
   task automatic test_backpressure;
      long_hold = 400;
      for (int i = 0; i < 20; i++) send_reading(1'($urandom_range(0, 1)), random_raw());
      drain();
   endtask

   initial begin
      errors = 0;
      cycles = 0;
      long_hold = 0;
      stall_left = 0;
      req_gaps = 1'b1;
      rsp_stalls = 1'b1;
      temp_coeffs = '0;
      press_low = '0;
      press_high = '0;
      press_nine = '0;
      fine_temp = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_directed();
      test_random_phases(6, 80);
      test_backpressure();
      test_random_phases(3, 50);
      // last part with no idling on either side
      req_gaps = 1'b0;
      rsp_stalls = 1'b0;
      test_random_phases(1, 60);
      repeat (50) @(posedge clock);
      $display("covered %0d temperature and %0d pressure readings, %0d results checked",
               temps_sent, pressures_sent, checked);
      $display("zero divisor results: %0d, mismatches: %0d", invalids_seen, errors);
      if (errors == 0 && pending_readings.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
`default_nettype wire

// ===== files.f =====
hw/rtl/tpc_pkg.sv
hw/rtl/temp_pressure_compensation.sv
tb/temp_pressure_compensation_test.sv
